/* hw/rtl/mbps_pkg.sv */
// ============================================================================
// mbps_pkg: shared definitions for the masked byte pattern scan
// Constants, configuration register indexes and the control structs that
// pass between the top level and the window cells.
// ============================================================================
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 24;
    localparam int OFFSET_BITS       = 32;
    localparam int MATCH_OFFSET_W    = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int LENGTH_W          = 5;
    localparam int PATTERN_W         = 8 * MAX_PATTERN_BYTES;

    // Configuration register indexes, selected by cfg_index.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_MID  = 3'd1,
        CFG_PATTERN_HIGH = 3'd2,
        CFG_MASK_LOW     = 3'd3,
        CFG_MASK_MID     = 3'd4,
        CFG_MASK_HIGH    = 3'd5,
        CFG_LENGTH       = 3'd6,
        CFG_ENABLE       = 3'd7
    } cfg_index_t;

    // Window movement for every cell in a cycle.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Pattern byte and mask that one cell compares against.
    typedef struct packed {
        logic       in_use;
        logic [7:0] pattern;
        logic [7:0] mask;
    } cell_ref_t;

endpackage

/* hw/rtl/mbps_cell.sv */
// ============================================================================
// mbps_cell: one byte position of the scan window
// Holds one window byte and its valid flag, hands them to the next cell on
// every shift, and compares the byte it is about to take with its pattern
// byte under the mask.
// ============================================================================
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_ref_t  ref_sel,
    input  logic [7:0] byte_in,
    input  logic       valid_in,
    output logic [7:0] byte_out,
    output logic       valid_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       valid_next;

    // The compare looks at the value this cell holds after the shift, so a
    // match is known in the same cycle the byte is accepted.
    assign hit = !ref_sel.in_use ||
                 (valid_in && (((byte_in ^ ref_sel.pattern) & ref_sel.mask) == 8'h00));

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* hw/rtl/masked_byte_pattern_scan_core.sv */
// ============================================================================
// masked_byte_pattern_scan_core: masked byte pattern search over a region
// Scans a byte stream for a masked pattern of up to 24 bytes and reports the
// first match offset of each region, or not found at the region end.
// ============================================================================
// Usage:
// A region enters on the input channel one byte per request (data_byte), with
// last_byte set on its final byte. A request is taken when in_valid is high
// and in_stall is low. Each region gives exactly one result on the output
// channel: found with the start offset of the first match, or found low and
// a zero offset when the region ends without a match. Bytes after a match up
// to the end of the region give no result.
// The result of a byte shows on out_valid in the cycle after that byte was
// taken. Throughput is one byte per cycle while in_stall is low, set by the
// combinational masked compare across the chain of window cells.
// The output register holds a result until it is taken; while out_valid is
// high and out_stall is high, in_stall rises and no byte is taken.
// The configuration channel is always ready and writes one register from the
// 64-bit cfg_data per request; writes are to be made between bytes, which
// the block does not enforce. Reset clears the registers, the window valid
// flags, byte count and match flag, so the next byte starts a fresh region.
// ============================================================================
module masked_byte_pattern_scan_core
    import mbps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // Byte input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    // Result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [MATCH_OFFSET_W-1:0] match_offset
);

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_mid_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [CFG_DATA_W-1:0] mask_low_reg;
    logic [CFG_DATA_W-1:0] mask_mid_reg;
    logic [CFG_DATA_W-1:0] mask_high_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic                  enable_reg;

    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_mid_reg  <= '0;
            pattern_high_reg <= '0;
            mask_low_reg     <= '0;
            mask_mid_reg     <= '0;
            mask_high_reg    <= '0;
            length_reg       <= '0;
            enable_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                CFG_PATTERN_MID:  pattern_mid_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                CFG_MASK_LOW:     mask_low_reg     <= cfg_data;
                CFG_MASK_MID:     mask_mid_reg     <= cfg_data;
                CFG_MASK_HIGH:    mask_high_reg    <= cfg_data;
                CFG_LENGTH:       length_reg       <= cfg_data[LENGTH_W-1:0];
                CFG_ENABLE:       enable_reg       <= cfg_data[0];
                default:          enable_reg       <= enable_reg;
            endcase
        end
    end

    // Pattern byte i sits in bits 8*i+7 : 8*i of these vectors.
    logic [PATTERN_W-1:0] pattern_vec;
    logic [PATTERN_W-1:0] mask_vec;

    assign pattern_vec = {pattern_high_reg, pattern_mid_reg, pattern_low_reg};
    assign mask_vec    = {mask_high_reg, mask_mid_reg, mask_low_reg};

    // Lengths above the window size never match, and neither does zero.
    logic length_ok;

    assign length_ok = (length_reg != '0) &&
                       (length_reg <= LENGTH_W'(MAX_PATTERN_BYTES));

    // ------------------------------------------------------------------
    // Handshake and region control
    // ------------------------------------------------------------------
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      found_reg;
    logic                      found_next;
    logic [MATCH_OFFSET_W-1:0] offset_reg;
    logic [MATCH_OFFSET_W-1:0] offset_next;
    logic                      matched_reg;
    logic                      matched_next;
    logic [OFFSET_BITS-1:0]    seen_reg;
    logic [OFFSET_BITS-1:0]    seen_next;
    logic [OFFSET_BITS-1:0]    seen_inc;
    logic [OFFSET_BITS-1:0]    start_pos;

    logic                      in_accept;
    logic                      scan_active;
    logic                      window_hit;
    logic                      result_load;
    cell_ctrl_t                cell_ctrl;

    // A byte can be taken whenever the output register is empty or drains
    // in this cycle.
    assign in_stall    = out_valid_reg && out_stall;
    assign in_accept   = in_valid && !in_stall;
    assign scan_active = in_accept && !matched_reg;

    assign cell_ctrl.shift = scan_active;
    assign cell_ctrl.clear = in_accept && last_byte;

    // ------------------------------------------------------------------
    // Window cell chain: cell k holds the byte k positions back from the
    // newest one. Cell k is checked against pattern byte length-1-k.
    // ------------------------------------------------------------------
    logic [7:0] chain_byte  [MAX_PATTERN_BYTES+1];
    logic       chain_valid [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] cell_hit;

    assign chain_byte[0]  = data_byte;
    assign chain_valid[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++)
    begin : g_cell
        localparam logic [LENGTH_W-1:0] CellPos = LENGTH_W'(k);

        logic                in_use;
        logic [LENGTH_W-1:0] sel_idx;
        cell_ref_t           ref_sel;

        assign in_use  = length_ok && (CellPos < length_reg);
        assign sel_idx = in_use ? (length_reg - LENGTH_W'(1) - CellPos) : '0;

        assign ref_sel.in_use  = in_use;
        assign ref_sel.pattern = pattern_vec[{sel_idx, 3'b000} +: 8];
        assign ref_sel.mask    = mask_vec[{sel_idx, 3'b000} +: 8];

        mbps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .ref_sel   (ref_sel),
            .byte_in   (chain_byte[k]),
            .valid_in  (chain_valid[k]),
            .byte_out  (chain_byte[k+1]),
            .valid_out (chain_valid[k+1]),
            .hit       (cell_hit[k])
        );
    end

    // The last cell's outputs have no neighbor to feed.
    logic chain_tail_unused;

    assign chain_tail_unused = ^chain_byte[MAX_PATTERN_BYTES] ^
                               chain_valid[MAX_PATTERN_BYTES];

    // Every cell in use must hold a byte of this region and agree with its
    // pattern byte; a cell holding no region byte means too few bytes seen.
    assign window_hit = enable_reg && length_ok && (&cell_hit);

    // ------------------------------------------------------------------
    // Byte count and result
    // ------------------------------------------------------------------
    assign seen_inc  = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 1'b1;
    assign start_pos = seen_inc - OFFSET_BITS'(length_reg);

    assign result_load = scan_active && (window_hit || last_byte);

    always_comb
    begin
        matched_next = matched_reg;
        seen_next    = seen_reg;
        if (in_accept && last_byte)
        begin
            matched_next = 1'b0;
            seen_next    = '0;
        end
        else if (scan_active)
        begin
            matched_next = window_hit;
            seen_next    = seen_inc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
            found_next     = window_hit;
            offset_next    = window_hit ? MATCH_OFFSET_W'(start_pos) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            matched_reg   <= matched_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next ^ {MATCH_OFFSET_W{1'b0 & chain_tail_unused}};
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

endmodule

/* hw/rtl/mbps_checker.sv */
// ============================================================================
// mbps_checker: port-level checks for the masked byte pattern scan
// Watches the top level's ports and flags results that break the block's
// contract over time.
// ============================================================================
module mbps_checker
    import mbps_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      found,
    input logic [MATCH_OFFSET_W-1:0] match_offset
);

    // A not-found result always carries a zero offset.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_offset == '0))
        else $error("not-found result with nonzero offset");

    // A held result does not change while the receiver stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(match_offset)))
        else $error("stalled result changed");

    // The input is only held off by a full, stalled output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A rise of out_valid only follows a byte taken in the cycle before.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without an accepted byte");

endmodule

bind masked_byte_pattern_scan_core mbps_checker u_mbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset)
);
